// ----- src/pps_pkg.sv -----
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int COUNT_W   = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 32;
  localparam int ARR_W     = 16;
  localparam int PRI_W     = 8;
  localparam int BURST_W   = 16;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [SLOT_W-1:0]  slot;
    logic [ARR_W-1:0]   arrival_time;
    logic [PRI_W-1:0]   priority_level;
    logic [BURST_W-1:0] burst_time;
  } request_t;

  typedef struct packed {
    logic              idle;
    logic [SLOT_W-1:0] running_slot;
    logic [TIME_W-1:0] time_now;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] total_waiting;
    logic [TIME_W-1:0] total_turnaround;
    logic              all_done;
  } result_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_FETCH = 7'b0001000,
    ST_EXEC  = 7'b0010000,
    ST_WAIT  = 7'b0100000,
    ST_SUM   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic tick_start;
    logic scan;
    logic fetch;
    logic exec;
    logic calc_wait;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic all_done;
    logic scan_last;
    logic found;
  } dp_status_t;

endpackage

// ----- src/preemptive_priority_scheduler.sv -----
// Channel        Signals                    Direction  Transaction
// request        start, busy, request       in         start high while busy low
// result         done, result               out        done high for one cycle
// configuration  cfg_we, cfg_wdata          in         cfg_we high
//
// A load transaction is absorbed at its accept edge and busy stays low.
// A tick scans the slots in use, one per cycle, then holds busy through DRAIN,
// FETCH, EXEC, WAIT, SUM (no EXEC, WAIT if none arrived; SUM alone if all done).
// The result strobe is high in the first cycle with busy low again.
// Reset is synchronous, clears the completion flags, clock and sums, and sets the count to one.
// The receiver cannot stall: done is high for exactly one cycle; result holds until the next.
module preemptive_priority_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  pps_pkg::request_t           request,
  output logic                        done,
  output pps_pkg::result_t            result,
  input  logic                        cfg_we,
  input  logic [pps_pkg::COUNT_W-1:0] cfg_wdata
);

  pps_pkg::ctrl_cmd_t  cmd;
  pps_pkg::dp_status_t status;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (request.req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  pps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule

// ----- src/pps_ctrl.sv -----
module pps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                req_type,
  input  pps_pkg::dp_status_t status,
  output pps_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  pps_pkg::state_t state;
  pps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != pps_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (start) begin
          if (req_type == pps_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.tick_start = 1'b1;
            state_next     = status.all_done ? pps_pkg::ST_SUM : pps_pkg::ST_SCAN;
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = pps_pkg::ST_DRAIN;
        end
      end
      pps_pkg::ST_DRAIN: begin
        state_next = pps_pkg::ST_FETCH;
      end
      pps_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = status.found ? pps_pkg::ST_EXEC : pps_pkg::ST_SUM;
      end
      pps_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = pps_pkg::ST_WAIT;
      end
      pps_pkg::ST_WAIT: begin
        cmd.calc_wait = 1'b1;
        state_next    = pps_pkg::ST_SUM;
      end
      pps_pkg::ST_SUM: begin
        cmd.report = 1'b1;
        state_next = pps_pkg::ST_IDLE;
      end
      default: begin
        state_next = pps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/pps_datapath.sv -----
module pps_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pps_pkg::COUNT_W-1:0]   cfg_wdata,
  input  pps_pkg::request_t             request,
  input  pps_pkg::ctrl_cmd_t            cmd,
  output pps_pkg::dp_status_t           status,
  output pps_pkg::result_t              result,
  output logic                          done
);

  typedef struct packed {
    logic [pps_pkg::ARR_W-1:0]   arrival;
    logic [pps_pkg::PRI_W-1:0]   prio;
    logic [pps_pkg::BURST_W-1:0] burst;
    logic [pps_pkg::BURST_W-1:0] remaining;
  } entry_t;

  localparam logic [pps_pkg::TIME_W-1:0] TIME_MAX = '1;

  function automatic logic [pps_pkg::TIME_W-1:0] sat_add(
    input logic [pps_pkg::TIME_W-1:0] a,
    input logic [pps_pkg::TIME_W-1:0] b
  );
    logic [pps_pkg::TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[pps_pkg::TIME_W] ? TIME_MAX : s[pps_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [pps_pkg::TIME_W-1:0] floor_sub(
    input logic [pps_pkg::TIME_W-1:0] a,
    input logic [pps_pkg::TIME_W-1:0] b
  );
    return (a > b) ? (a - b) : '0;
  endfunction

  entry_t                          table_mem [pps_pkg::MAX_PROCS];
  entry_t                          rd_data;
  logic [pps_pkg::SLOT_W-1:0]      rd_slot;
  logic                            rd_vld;
  logic [pps_pkg::MAX_PROCS-1:0]   completed;
  logic [pps_pkg::COUNT_W-1:0]     process_count;
  logic [pps_pkg::COUNT_W-1:0]     count_eff;
  logic [pps_pkg::SLOT_W-1:0]      scan_idx;
  logic                            found;
  logic [pps_pkg::SLOT_W-1:0]      best_slot;
  logic [pps_pkg::PRI_W-1:0]       best_pri;
  logic                            fin;
  logic [pps_pkg::TIME_W-1:0]      current_time;
  logic [pps_pkg::TIME_W-1:0]      waiting_sum;
  logic [pps_pkg::TIME_W-1:0]      turnaround_sum;
  logic [pps_pkg::TIME_W-1:0]      tat;
  logic [pps_pkg::TIME_W-1:0]      wait_time;
  logic                            candidate;
  logic                            all_done;
  logic                            last_unit;
  logic [pps_pkg::BURST_W-1:0]     remaining_next;
  logic [pps_pkg::TIME_W-1:0]      waiting_sum_next;
  logic [pps_pkg::TIME_W-1:0]      turnaround_sum_next;
  logic                            fin_report;

  always_comb begin
    if (process_count == '0) begin
      count_eff = pps_pkg::COUNT_W'(1);
    end else if (process_count > pps_pkg::COUNT_W'(pps_pkg::MAX_PROCS)) begin
      count_eff = pps_pkg::COUNT_W'(pps_pkg::MAX_PROCS);
    end else begin
      count_eff = process_count;
    end
  end

  always_comb begin
    all_done = 1'b1;
    for (int k = 0; k < pps_pkg::MAX_PROCS; k++) begin
      if ((pps_pkg::COUNT_W'(k) < count_eff) && !completed[k]) begin
        all_done = 1'b0;
      end
    end
  end

  assign status.all_done  = all_done;
  assign status.scan_last = ({1'b0, scan_idx} == (count_eff - pps_pkg::COUNT_W'(1)));
  assign status.found     = found;

  assign candidate = rd_vld
                  && ({{(pps_pkg::TIME_W - pps_pkg::ARR_W){1'b0}}, rd_data.arrival}
                      <= current_time)
                  && !completed[rd_slot]
                  && (!found || (rd_data.prio > best_pri));

  assign last_unit      = (rd_data.remaining <= pps_pkg::BURST_W'(1));
  assign remaining_next = last_unit ? '0 : (rd_data.remaining - pps_pkg::BURST_W'(1));

  assign fin_report          = found && fin;
  assign waiting_sum_next    = fin_report ? sat_add(waiting_sum, wait_time) : waiting_sum;
  assign turnaround_sum_next = fin_report ? sat_add(turnaround_sum, tat) : turnaround_sum;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      table_mem[request.slot] <= '{arrival:   request.arrival_time,
                                   prio:      request.priority_level,
                                   burst:     request.burst_time,
                                   remaining: request.burst_time};
    end else if (cmd.exec) begin
      table_mem[best_slot] <= '{arrival:   rd_data.arrival,
                                prio:      rd_data.prio,
                                burst:     rd_data.burst,
                                remaining: remaining_next};
    end
    if (cmd.scan) begin
      rd_data <= table_mem[scan_idx];
      rd_slot <= scan_idx;
    end else if (cmd.fetch) begin
      rd_data <= table_mem[best_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= pps_pkg::COUNT_W'(1);
      completed      <= '0;
      current_time   <= '0;
      waiting_sum    <= '0;
      turnaround_sum <= '0;
      rd_vld         <= 1'b0;
      scan_idx       <= '0;
      found          <= 1'b0;
      fin            <= 1'b0;
      done           <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      done   <= cmd.report;
      if (cfg_we) begin
        process_count <= cfg_wdata;
      end
      if (cmd.load) begin
        completed[request.slot] <= 1'b0;
      end
      if (cmd.tick_start) begin
        scan_idx <= '0;
        found    <= 1'b0;
        fin      <= 1'b0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + pps_pkg::SLOT_W'(1);
      end
      if (candidate) begin
        found <= 1'b1;
      end
      if (cmd.fetch) begin
        current_time <= sat_add(current_time, pps_pkg::TIME_W'(1));
      end
      if (cmd.exec) begin
        fin <= last_unit;
        if (last_unit) begin
          completed[best_slot] <= 1'b1;
        end
      end
      if (cmd.report) begin
        waiting_sum    <= waiting_sum_next;
        turnaround_sum <= turnaround_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (candidate) begin
      best_slot <= rd_slot;
      best_pri  <= rd_data.prio;
    end
    if (cmd.exec) begin
      tat <= floor_sub(current_time,
                       {{(pps_pkg::TIME_W - pps_pkg::ARR_W){1'b0}}, rd_data.arrival});
    end
    if (cmd.calc_wait) begin
      wait_time <= floor_sub(tat,
                             {{(pps_pkg::TIME_W - pps_pkg::BURST_W){1'b0}}, rd_data.burst});
    end
    if (cmd.report) begin
      result.idle             <= !found;
      result.running_slot     <= found ? best_slot : '0;
      result.time_now         <= current_time;
      result.finished         <= fin_report;
      result.completion_time  <= fin_report ? current_time : '0;
      result.turnaround_time  <= fin_report ? tat : '0;
      result.waiting_time     <= fin_report ? wait_time : '0;
      result.total_waiting    <= waiting_sum_next;
      result.total_turnaround <= turnaround_sum_next;
      result.all_done         <= all_done;
    end
  end

endmodule
